/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dpcr_pkg.sv */
`default_nettype none
package dpcr_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS      = 2'd0,
        CFG_DAMPING     = 2'd1,
        CFG_RESTITUTION = 2'd2
    } t_cfg_idx;

    localparam int unsigned RAD_W     = 25;
    localparam int unsigned FRAC_W    = 17;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned MD_W      = RAD_W + 1;
    localparam int unsigned DX_W      = 34;
    localparam int unsigned D_W       = 27;
    localparam int unsigned Q_W       = 54;
    localparam int unsigned MDQ_W     = 2 * MD_W;
    localparam int unsigned L_W       = 27;
    localparam int unsigned NUM_W     = 43;
    localparam int unsigned DVS_W     = NUM_W + 1;
    localparam int unsigned NRM_W     = 17;
    localparam int unsigned C_W       = 26;
    localparam int unsigned PRD_W     = L_W + FRAC_W;
    localparam int unsigned CM_W      = 27;
    localparam int unsigned PC_W      = NRM_W + C_W;
    localparam int unsigned REL_W     = 33;
    localparam int unsigned T_W       = 34;
    localparam int unsigned PT_W      = REL_W + NRM_W;
    localparam int unsigned S_W       = 36;
    localparam int unsigned RST_W     = FRAC_W + 1;
    localparam int unsigned PJ_W      = S_W + RST_W;
    localparam int unsigned J_W       = 36;
    localparam int unsigned PK_W      = J_W + NRM_W;
    localparam int unsigned JM_W      = 37;
    localparam int unsigned SAT_W     = 40;

    localparam int unsigned SQ_STAGES  = 27;
    localparam int unsigned DIV_STAGES = 17;

    localparam logic [RAD_W-1:0]  RADIUS_RST  = 25'd65536;
    localparam logic [FRAC_W-1:0] DAMPING_RST = 17'd45875;
    localparam logic [FRAC_W-1:0] REST_RST    = 17'd6554;
    localparam logic [NRM_W-1:0]  ONE_Q16     = 17'd65536;

    typedef struct packed {
        logic signed [31:0] pos_a_x;
        logic signed [31:0] pos_a_y;
        logic signed [31:0] pos_b_x;
        logic signed [31:0] pos_b_y;
        logic signed [31:0] vel_a_x;
        logic signed [31:0] vel_a_y;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_b_y;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] new_pos_a_x;
        logic signed [31:0] new_pos_a_y;
        logic signed [31:0] new_pos_b_x;
        logic signed [31:0] new_pos_b_y;
        logic signed [31:0] new_vel_a_x;
        logic signed [31:0] new_vel_a_y;
        logic signed [31:0] new_vel_b_x;
        logic signed [31:0] new_vel_b_y;
        logic               overlapped;
        logic               impulse_applied;
    } t_out_rsp;

    typedef struct packed {
        logic [RAD_W-1:0]  radius;
        logic [FRAC_W-1:0] damping;
        logic [FRAC_W-1:0] restitution;
    } t_cfg;

    // classified request as it sits in the queue
    typedef struct packed {
        t_in_req                orig;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic [Q_W-1:0]         q;
        logic                   hit;
    } t_cls;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // square root and divide working set
    typedef struct packed {
        t_in_req                orig;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic                   hit;
        logic [Q_W-1:0]         x;
        logic [Q_W-1:0]         r;
        logic [L_W-1:0]         l;
        logic [NUM_W-1:0]       rx;
        logic [NUM_W-1:0]       ry;
        logic [NRM_W-1:0]       qx;
        logic [NRM_W-1:0]       qy;
        logic [C_W-1:0]         c;
    } t_work;

    // response math working set
    typedef struct packed {
        t_in_req                 orig;
        logic                    hit;
        logic [C_W-1:0]          c;
        logic [NRM_W-1:0]        nmx;
        logic [NRM_W-1:0]        nmy;
        logic                    nsx;
        logic                    nsy;
        logic signed [REL_W-1:0] relx;
        logic signed [REL_W-1:0] rely;
        logic [CM_W-1:0]         cmx;
        logic [CM_W-1:0]         cmy;
        logic [T_W-1:0]          tmx;
        logic [T_W-1:0]          tmy;
        logic                    tsx;
        logic                    tsy;
        logic [S_W-1:0]          s;
        logic                    sneg;
        logic [J_W-1:0]          j;
        logic [JM_W-1:0]         jmx;
        logic [JM_W-1:0]         jmy;
    } t_mth;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-32:0] hi;
        hi = v[SAT_W-1:31];
        if (hi == '0 || hi == '1) begin
            return v[31:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {31{1'b0}}};
        end else begin
            return {1'b0, {31{1'b1}}};
        end
    endfunction

    // one result bit of the integer square root, stage k from the top
    function automatic t_work sqrt_step(input t_work w, input int unsigned k);
        t_work          o;
        logic [Q_W-1:0] b;
        logic [Q_W-1:0] t;
        o = w;
        b = Q_W'(1) << (2 * (SQ_STAGES - 1 - k));
        t = w.r + b;
        if (w.x >= t) begin
            o.x = w.x - t;
            o.r = (w.r >> 1) + b;
        end else begin
            o.r = w.r >> 1;
        end
        return o;
    endfunction

    // distance known: set up dividends and the push distance
    function automatic t_work prep_step(input t_work w, input logic [MD_W-1:0] md,
                                        input logic [FRAC_W-1:0] damp);
        t_work            o;
        logic [D_W-1:0]   mx;
        logic [D_W-1:0]   my;
        logic [L_W-1:0]   gap;
        logic [PRD_W-1:0] prod;
        o    = w;
        o.l  = w.r[L_W-1:0];
        mx   = w.dx[D_W-1] ? D_W'(-w.dx) : D_W'(w.dx);
        my   = w.dy[D_W-1] ? D_W'(-w.dy) : D_W'(w.dy);
        o.rx = NUM_W'(mx) << FRAC_BITS;
        o.ry = NUM_W'(my) << FRAC_BITS;
        o.qx = '0;
        o.qy = '0;
        gap  = L_W'(md) - o.l;
        prod = PRD_W'(gap) * PRD_W'(damp);
        o.c  = C_W'(prod >> FRAC_W);
        return o;
    endfunction

    // one quotient bit of both normal components, bit i
    function automatic t_work div_step(input t_work w, input int unsigned i);
        t_work            o;
        logic [DVS_W-1:0] dvs;
        o   = w;
        dvs = DVS_W'(w.l) << i;
        if ({1'b0, w.rx} >= dvs) begin
            o.rx = NUM_W'({1'b0, w.rx} - dvs);
            o.qx = w.qx | (NRM_W'(1) << i);
        end
        if ({1'b0, w.ry} >= dvs) begin
            o.ry = NUM_W'({1'b0, w.ry} - dvs);
            o.qy = w.qy | (NRM_W'(1) << i);
        end
        return o;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/dpcr_front.sv */
`default_nettype none
module dpcr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dpcr_pkg::t_in_req i_in_req,
    input  dpcr_pkg::t_cfg    i_cfg,
    input  dpcr_pkg::t_q_stat i_qstat,
    output logic              o_push,
    output dpcr_pkg::t_cls    o_cls
);
    import dpcr_pkg::*;

    typedef struct packed {
        t_in_req               orig;
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic                  inr;
    } t_f0;

    typedef struct packed {
        t_in_req               orig;
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic [Q_W-1:0]        sqx;
        logic [Q_W-1:0]        sqy;
        logic [MDQ_W-1:0]      mdq;
        logic                  inr;
    } t_f1;

    logic [2:0]       r_fv;
    t_f0              r_f0, n_f0;
    t_f1              r_f1, n_f1;
    t_cls             r_f2, n_f2;
    logic             w_en;
    logic [MD_W-1:0]  w_md;

    assign w_md       = {i_cfg.radius, 1'b0};
    assign w_en       = !r_fv[2] || !i_qstat.full;
    assign o_in_ready = w_en;
    assign o_push     = r_fv[2] && !i_qstat.full;
    assign o_cls      = r_f2;

    always_comb begin
        logic signed [DX_W-1:0] dxw;
        logic signed [DX_W-1:0] dyw;
        logic signed [DX_W-1:0] mds;
        dxw = DX_W'(i_in_req.pos_b_x) - DX_W'(i_in_req.pos_a_x);
        dyw = DX_W'(i_in_req.pos_b_y) - DX_W'(i_in_req.pos_a_y);
        mds = $signed(DX_W'(w_md));
        n_f0.orig = i_in_req;
        n_f0.dx   = dxw[D_W-1:0];
        n_f0.dy   = dyw[D_W-1:0];
        // any component at or past the contact distance means no contact
        n_f0.inr  = (dxw < mds) && (dxw > -mds) && (dyw < mds) && (dyw > -mds);
    end

    always_comb begin
        logic signed [Q_W-1:0] ex;
        logic signed [Q_W-1:0] ey;
        ex = Q_W'(r_f0.dx);
        ey = Q_W'(r_f0.dy);
        n_f1.orig = r_f0.orig;
        n_f1.dx   = r_f0.dx;
        n_f1.dy   = r_f0.dy;
        n_f1.sqx  = ex * ex;
        n_f1.sqy  = ey * ey;
        n_f1.mdq  = MDQ_W'(w_md) * MDQ_W'(w_md);
        n_f1.inr  = r_f0.inr;
    end

    always_comb begin
        logic [Q_W-1:0] q;
        q = r_f1.sqx + r_f1.sqy;
        n_f2.orig = r_f1.orig;
        n_f2.dx   = r_f1.dx;
        n_f2.dy   = r_f1.dy;
        n_f2.q    = q;
        n_f2.hit  = r_f1.inr && (q != '0) && (q < Q_W'(r_f1.mdq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[1:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f0 <= n_f0;
            r_f1 <= n_f1;
            r_f2 <= n_f2;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/dpcr_fifo.sv */
`default_nettype none
module dpcr_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dpcr_pkg::t_cls    i_data,
    input  logic              i_pop,
    output dpcr_pkg::t_cls    o_data,
    output dpcr_pkg::t_q_stat o_stat
);
    import dpcr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign w_wr          = i_push && (r_cnt != CNT_W'(DEPTH));
    assign w_rd          = i_pop && (r_cnt != '0);
    assign o_data        = r_mem[r_rd];
    assign o_stat.full   = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty  = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/dpcr_back.sv */
`default_nettype none
module dpcr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dpcr_pkg::t_q_stat  i_qstat,
    input  dpcr_pkg::t_cls     i_cls,
    output logic               o_pop,
    input  dpcr_pkg::t_cfg     i_cfg,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dpcr_pkg::t_out_rsp o_out_rsp
);
    import dpcr_pkg::*;

    localparam int unsigned NW = SQ_STAGES + DIV_STAGES + 2;
    localparam int unsigned NM = 5;
    localparam int unsigned NV = NW + NM;

    logic            w_en;
    logic [NV-1:0]   r_v;
    t_work           r_w [NW];
    t_work           n_w0;
    t_mth            r_m [NM];
    t_mth            n_m [NM];
    logic            r_ov;
    t_out_rsp        r_out, n_out;
    logic [MD_W-1:0] w_md;

    assign w_md        = {i_cfg.radius, 1'b0};
    assign w_en        = !r_ov || i_out_ready;
    assign o_pop       = w_en && !i_qstat.empty;
    assign o_out_valid = r_ov;
    assign o_out_rsp   = r_out;

    always_comb begin
        n_w0      = '0;
        n_w0.orig = i_cls.orig;
        n_w0.dx   = i_cls.dx;
        n_w0.dy   = i_cls.dy;
        n_w0.hit  = i_cls.hit;
        n_w0.x    = i_cls.q;
    end

    always_comb begin
        t_work           w;
        logic [REL_W-1:0] rmx;
        logic [REL_W-1:0] rmy;
        logic [S_W-1:0]   sx;
        logic [S_W-1:0]   sy;
        logic [S_W-1:0]   smag;
        w = r_w[NW-1];

        // normal components, sign and magnitude
        n_m[0]      = '0;
        n_m[0].orig = w.orig;
        n_m[0].hit  = w.hit;
        n_m[0].c    = w.c;
        n_m[0].nmx  = (w.qx > ONE_Q16) ? ONE_Q16 : w.qx;
        n_m[0].nmy  = (w.qy > ONE_Q16) ? ONE_Q16 : w.qy;
        n_m[0].nsx  = w.dx[D_W-1];
        n_m[0].nsy  = w.dy[D_W-1];
        n_m[0].relx = REL_W'(w.orig.vel_a_x) - REL_W'(w.orig.vel_b_x);
        n_m[0].rely = REL_W'(w.orig.vel_a_y) - REL_W'(w.orig.vel_b_y);

        // push amounts and relative speed terms along -n
        n_m[1]     = r_m[0];
        rmx        = r_m[0].relx[REL_W-1] ? REL_W'(-r_m[0].relx) : REL_W'(r_m[0].relx);
        rmy        = r_m[0].rely[REL_W-1] ? REL_W'(-r_m[0].rely) : REL_W'(r_m[0].rely);
        n_m[1].cmx = CM_W'((PC_W'(r_m[0].nmx) * PC_W'(r_m[0].c)) >> FRAC_BITS);
        n_m[1].cmy = CM_W'((PC_W'(r_m[0].nmy) * PC_W'(r_m[0].c)) >> FRAC_BITS);
        n_m[1].tmx = T_W'((PT_W'(rmx) * PT_W'(r_m[0].nmx)) >> FRAC_BITS);
        n_m[1].tmy = T_W'((PT_W'(rmy) * PT_W'(r_m[0].nmy)) >> FRAC_BITS);
        n_m[1].tsx = r_m[0].relx[REL_W-1] ^ !r_m[0].nsx;
        n_m[1].tsy = r_m[0].rely[REL_W-1] ^ !r_m[0].nsy;

        n_m[2]      = r_m[1];
        sx          = S_W'(r_m[1].tmx);
        sy          = S_W'(r_m[1].tmy);
        n_m[2].s    = (r_m[1].tsx ? -sx : sx) + (r_m[1].tsy ? -sy : sy);
        n_m[2].sneg = n_m[2].s[S_W-1];

        // impulse magnitude, only meaningful when approaching
        n_m[3]   = r_m[2];
        smag     = r_m[2].sneg ? -r_m[2].s : r_m[2].s;
        n_m[3].j = J_W'((PJ_W'(smag) * PJ_W'(RST_W'(ONE_Q16) + RST_W'(i_cfg.restitution)))
                        >> FRAC_W);

        n_m[4]     = r_m[3];
        n_m[4].jmx = JM_W'((PK_W'(r_m[3].j) * PK_W'(r_m[3].nmx)) >> FRAC_BITS);
        n_m[4].jmy = JM_W'((PK_W'(r_m[3].j) * PK_W'(r_m[3].nmy)) >> FRAC_BITS);
    end

    always_comb begin
        t_mth                    m;
        logic signed [SAT_W-1:0] pax, pay, pbx, pby;
        logic signed [SAT_W-1:0] vax, vay, vbx, vby;
        logic signed [SAT_W-1:0] cx, cy, jx, jy;
        logic                    imp;
        m   = r_m[NM-1];
        imp = m.hit && m.sneg;
        pax = SAT_W'(m.orig.pos_a_x);
        pay = SAT_W'(m.orig.pos_a_y);
        pbx = SAT_W'(m.orig.pos_b_x);
        pby = SAT_W'(m.orig.pos_b_y);
        vax = SAT_W'(m.orig.vel_a_x);
        vay = SAT_W'(m.orig.vel_a_y);
        vbx = SAT_W'(m.orig.vel_b_x);
        vby = SAT_W'(m.orig.vel_b_y);
        cx  = m.nsx ? -$signed(SAT_W'(m.cmx)) : $signed(SAT_W'(m.cmx));
        cy  = m.nsy ? -$signed(SAT_W'(m.cmy)) : $signed(SAT_W'(m.cmy));
        jx  = m.nsx ? -$signed(SAT_W'(m.jmx)) : $signed(SAT_W'(m.jmx));
        jy  = m.nsy ? -$signed(SAT_W'(m.jmy)) : $signed(SAT_W'(m.jmy));
        if (m.hit) begin
            pax = pax - cx;
            pay = pay - cy;
            pbx = pbx + cx;
            pby = pby + cy;
        end
        if (imp) begin
            vax = vax - jx;
            vay = vay - jy;
            vbx = vbx + jx;
            vby = vby + jy;
        end
        n_out.new_pos_a_x     = sat32(pax);
        n_out.new_pos_a_y     = sat32(pay);
        n_out.new_pos_b_x     = sat32(pbx);
        n_out.new_pos_b_y     = sat32(pby);
        n_out.new_vel_a_x     = sat32(vax);
        n_out.new_vel_a_y     = sat32(vay);
        n_out.new_vel_b_x     = sat32(vbx);
        n_out.new_vel_b_y     = sat32(vby);
        n_out.overlapped      = m.hit;
        n_out.impulse_applied = imp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v  <= {r_v[NV-2:0], o_pop};
            r_ov <= r_v[NV-1];
        end
    end

    // whole back pipeline moves together when the output slot frees up
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w[0] <= n_w0;
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_w[k+1] <= sqrt_step(r_w[k], k);
            end
            r_w[SQ_STAGES+1] <= prep_step(r_w[SQ_STAGES], w_md, i_cfg.damping);
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_w[SQ_STAGES+2+k] <= div_step(r_w[SQ_STAGES+1+k], DIV_STAGES - 1 - k);
            end
            for (int k = 0; k < NM; k++) begin
                r_m[k] <= n_m[k];
            end
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/disc_pair_collision_resolver_core.sv */
`default_nettype none
// Resolves one pair of equal discs per request: overlap test, separation push along the
// contact normal and an equal-mass restitution impulse, all in signed Q16.16 with saturated
// results. Sustained rate is one request per cycle while results are taken. A request
// reaches the queue after three front stages; the back pipeline then takes an entry register,
// 27 square-root stages (one root bit each), one setup stage, 17 divide stages (one normal bit
// each), five math stages and the output register. The front keeps accepting while a result
// waits, up to the queue depth plus its three stages. Registers may be written only while no
// request is in flight.
module disc_pair_collision_resolver_core #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  dpcr_pkg::t_in_req                   i_in_req,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output dpcr_pkg::t_out_rsp                  o_out_rsp,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dpcr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dpcr_pkg::RAD_W-1:0]          i_cfg_data
);
    import dpcr_pkg::*;

    `include "assert_macros.svh"

    t_cfg    r_cfg;
    t_cls    w_push_data;
    t_cls    w_pop_data;
    t_q_stat w_qstat;
    logic    w_push;
    logic    w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius      <= RADIUS_RST;
            r_cfg.damping     <= DAMPING_RST;
            r_cfg.restitution <= REST_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RADIUS:      r_cfg.radius      <= i_cfg_data;
                CFG_DAMPING:     r_cfg.damping     <= i_cfg_data[FRAC_W-1:0];
                CFG_RESTITUTION: r_cfg.restitution <= i_cfg_data[FRAC_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    dpcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (i_in_req),
        .i_cfg      (r_cfg),
        .i_qstat    (w_qstat),
        .o_push     (w_push),
        .o_cls      (w_push_data)
    );

    dpcr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_stat  (w_qstat)
    );

    dpcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (w_qstat),
        .i_cls       (w_pop_data),
        .o_pop       (w_pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

    `ASSERT_IMPLY(a_imp_needs_ovl, o_out_valid && o_out_rsp.impulse_applied, o_out_rsp.overlapped, "impulse without overlap")
    `ASSERT_IMPLY(a_push_room, w_push, !w_qstat.full, "request pushed into full queue")
    `ASSERT_IMPLY(a_pop_data, w_pop, !w_qstat.empty, "pop from empty queue")
    `ASSERT_ALWAYS(a_qstat_sane, !(w_qstat.full && w_qstat.empty), "queue both full and empty")

endmodule
`default_nettype wire
